### design/hlvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hlvf_pkg;

   localparam int VAL_W = 32;
   localparam int VAR_W = 32;

   localparam logic [2:0] REG_FILTER_ENABLE  = 3'd0;
   localparam logic [2:0] REG_MEAS_NOISE_VAR = 3'd1;
   localparam logic [2:0] REG_PROC_NOISE_VAR = 3'd2;
   localparam logic [2:0] REG_VEL_LIMIT      = 3'd3;
   localparam logic [2:0] REG_FORCE_LIMIT    = 3'd4;
   localparam logic [2:0] REG_FORCE_DIVISOR  = 3'd5;

   typedef struct packed {
      logic        filter_enable;
      logic [31:0] meas_noise_var;
      logic [24:0] proc_noise_var;
      logic [30:0] vel_limit;
      logic [30:0] force_limit;
      logic [7:0]  force_divisor;
   } cfg_type;

   // Per-item control handed from the top level to every lane.
   typedef struct packed {
      logic       start;
      logic       fb_valid;
      logic       clutch;
      logic       no_force;
      logic [1:0] scale;
   } lane_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      begin
         if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
         else if (v < -36'sd2147483648) r = 32'sh80000000;
         else r = v[31:0];
         return r;
      end
   endfunction

   function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                     input logic [30:0] lim);
      logic signed [32:0] l;
      logic signed [31:0] r;
      begin
         l = $signed({2'b00, lim});
         if ($signed({v[31], v}) > l) r = {1'b0, lim};
         else if ($signed({v[31], v}) < -l) r = 32'(-l);
         else r = v;
         return r;
      end
   endfunction

endpackage
`default_nettype wire

### design/hlvf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hlvf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_vel_x;
   logic [31:0] raw_vel_y;
   logic [31:0] raw_vel_z;
   logic [31:0] fb_force_x;
   logic [31:0] fb_force_y;
   logic [31:0] fb_force_z;
   logic        fb_valid;
   logic        clutch_button;
   logic        toggle_button;
   logic        scale_button;
   modport source (output valid, raw_vel_x, raw_vel_y, raw_vel_z, fb_force_x, fb_force_y,
                   fb_force_z, fb_valid, clutch_button, toggle_button, scale_button,
                   input ready);
   modport sink (input valid, raw_vel_x, raw_vel_y, raw_vel_z, fb_force_x, fb_force_y,
                 fb_force_z, fb_valid, clutch_button, toggle_button, scale_button,
                 output ready);
endinterface

interface hlvf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cmd_vel_x;
   logic [31:0] cmd_vel_y;
   logic [31:0] cmd_vel_z;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [31:0] disp_force_x;
   logic [31:0] disp_force_y;
   logic [31:0] disp_force_z;
   logic        haptics_off;
   logic [1:0]  scale_level;
   modport source (output valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, pos_x, pos_y, pos_z,
                   disp_force_x, disp_force_y, disp_force_z, haptics_off, scale_level,
                   input ready);
   modport sink (input valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, pos_x, pos_y, pos_z,
                 disp_force_x, disp_force_y, disp_force_z, haptics_off, scale_level,
                 output ready);
endinterface

interface hlvf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/hlvf_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module hlvf_divider #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

### design/hlvf_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis: scale, Kalman update, clamp, integrate, force hold and display.
module hlvf_lane #(
   parameter logic signed [31:0] POS_RESET = 32'sd0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  hlvf_pkg::cfg_type          cfg,
   input  hlvf_pkg::lane_ctl_type     ctl,
   input  wire logic signed [31:0]    raw_vel,
   input  wire logic signed [31:0]    fb_force,
   output logic                       done,
   output logic signed [31:0]         cmd_vel,
   output logic signed [31:0]         pos,
   output logic signed [31:0]         disp_force
);
   import hlvf_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_GAIN  = 4'd1;
   localparam logic [3:0] ST_GWAIT = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_UPD   = 4'd4;
   localparam logic [3:0] ST_CLAMP = 4'd5;
   localparam logic [3:0] ST_POS   = 4'd6;
   localparam logic [3:0] ST_PMUL  = 4'd7;
   localparam logic [3:0] ST_PADD  = 4'd8;
   localparam logic [3:0] ST_FRC   = 4'd9;
   localparam logic [3:0] ST_FWAIT = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   // floor(n / 1000) is floor((n >> 3) / 125); for a 29-bit operand the product
   // with ceil(2^36 / 125) shifted right by 36 gives that quotient exactly.
   localparam logic [29:0] RECIP_125 = 30'd549755814;

   logic [3:0]         st_ff, st_in;
   logic signed [31:0] est_ff, est_in;
   logic [31:0]        p_ff, p_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] hf_ff, hf_in;
   logic signed [31:0] v_ff, v_in;
   logic [16:0]        k_ff, k_in;
   logic signed [50:0] kinn_ff, kinn_in;
   logic [48:0]        kp_ff, kp_in;
   logic signed [31:0] f_ff, f_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [31:0]        rn_ff, rn_in;
   logic [58:0]        pq_ff, pq_in;

   logic               dv_start;
   logic [47:0]        dv_num;
   logic [32:0]        dv_den;
   logic               dv_done;
   logic [47:0]        dv_q;

   logic signed [32:0] innov;
   logic signed [35:0] scaled;
   logic [50:0]        kmag;
   logic signed [35:0] est_sum;
   logic [34:0]        np;
   logic [31:0]        vmag;
   logic [7:0]         dvsr;

   hlvf_divider #(.NUM_W(48), .DEN_W(33)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quot(dv_q));

   always_comb begin
      st_in    = st_ff;
      est_in   = est_ff;
      p_in     = p_ff;
      pos_in   = pos_ff;
      hf_in    = hf_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      kinn_in  = kinn_ff;
      kp_in    = kp_ff;
      f_in     = f_ff;
      neg_in   = neg_ff;
      rn_in    = rn_ff;
      pq_in    = pq_ff;
      done_in  = 1'b0;
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      innov    = $signed({est_ff[31], est_ff});
      innov    = $signed({v_ff[31], v_ff}) - innov;
      scaled   = $signed({{4{raw_vel[31]}}, raw_vel})
               * $signed({1'b0, 1'b0, ctl.scale} + 4'sd1);
      kmag     = kinn_ff[50] ? 51'(-kinn_ff) : 51'(kinn_ff);
      kmag     = (kmag + 51'd32768) >> 16;
      est_sum  = $signed({{4{est_ff[31]}}, est_ff})
               + (kinn_ff[50] ? -$signed({1'b0, kmag[34:0]}) : $signed({1'b0, kmag[34:0]}));
      np       = {3'b0, p_ff} + {10'b0, cfg.proc_noise_var} - {2'b0, kp_ff[48:16]};
      vmag     = v_ff[31] ? 32'(-v_ff) : 32'(v_ff);
      dvsr     = (cfg.force_divisor == 8'd0) ? 8'd1 : cfg.force_divisor;
      unique case (st_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               v_in  = sat32(scaled);
               st_in = cfg.filter_enable ? ST_GAIN : ST_CLAMP;
            end
         end
         ST_GAIN: begin
            if (({1'b0, p_ff} + {1'b0, cfg.meas_noise_var}) == 33'd0) begin
               k_in  = '0;
               st_in = ST_MUL;
            end else begin
               dv_start = 1'b1;
               dv_num   = {p_ff, 16'b0};
               dv_den   = {1'b0, p_ff} + {1'b0, cfg.meas_noise_var};
               st_in    = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            if (dv_done) begin
               k_in  = dv_q[16:0];
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            kinn_in = $signed({1'b0, k_ff}) * innov;
            kp_in   = k_ff * p_ff;
            st_in   = ST_UPD;
         end
         ST_UPD: begin
            est_in = sat32(est_sum);
            v_in   = sat32(est_sum);
            p_in   = (np > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : np[31:0];
            st_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            v_in  = ctl.clutch ? 32'sd0 : clamp_mag(v_ff, cfg.vel_limit);
            st_in = ST_POS;
         end
         ST_POS: begin
            // The clamped magnitude is below 2^31, so the rounding offset cannot carry out.
            rn_in  = vmag + 32'd500;
            neg_in = v_ff[31];
            st_in  = ST_PMUL;
         end
         ST_PMUL: begin
            pq_in = {30'b0, rn_ff[31:3]} * {29'b0, RECIP_125};
            st_in = ST_PADD;
         end
         ST_PADD: begin
            pos_in = sat32($signed({{4{pos_ff[31]}}, pos_ff})
                   + (neg_ff ? -$signed({13'b0, pq_ff[58:36]})
                             : $signed({13'b0, pq_ff[58:36]})));
            hf_in = ctl.clutch ? 32'sd0
                  : clamp_mag(ctl.fb_valid ? fb_force : hf_ff, cfg.force_limit);
            st_in = ST_FRC;
         end
         ST_FRC: begin
            dv_start = 1'b1;
            dv_num   = {16'b0, (hf_ff[31] ? 32'(-hf_ff) : 32'(hf_ff))} + 48'(dvsr >> 1);
            dv_den   = {25'b0, dvsr};
            neg_in   = hf_ff[31];
            st_in    = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (dv_done) begin
               if (ctl.no_force || ctl.clutch) f_in = '0;
               else f_in = neg_ff ? $signed(dv_q[31:0]) : -$signed(dv_q[31:0]);
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done_in = 1'b1;
            st_in   = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         est_ff  <= '0;
         p_ff    <= '0;
         pos_ff  <= POS_RESET;
         hf_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         est_ff  <= est_in;
         p_ff    <= p_in;
         pos_ff  <= pos_in;
         hf_ff   <= hf_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      k_ff    <= k_in;
      kinn_ff <= kinn_in;
      kp_ff   <= kp_in;
      f_ff    <= f_in;
      neg_ff  <= neg_in;
      rn_ff   <= rn_in;
      pq_ff   <= pq_in;
   end

   assign done       = done_ff;
   assign cmd_vel    = v_ff;
   assign pos        = pos_ff;
   assign disp_force = f_ff;

`ifndef ASSERT_OFF
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_MUL) |-> (k_ff <= 17'd65536))
      else $error("gain above one");
   a_clutch_zero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_POS && ctl.clutch) |-> (v_ff == 32'sd0))
      else $error("velocity not zero under clutch");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("lane done longer than one cycle");
`endif
endmodule
`default_nettype wire

### design/haptic_leader_velocity_filter_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Each lane runs a serial gain division (filter on and a nonzero innovation variance)
// and a serial force division, both on its own restoring divider;
// the position rounding uses a reciprocal multiply. One transaction is handled at a time.
// A new request is not taken until the previous response has been accepted.
// Reset is synchronous, active high; it restores register defaults and filter state.
module haptic_leader_velocity_filter_step (
   input wire logic  clock,
   input wire logic  reset,
   hlvf_req_if.sink   req,
   hlvf_rsp_if.source rsp,
   hlvf_csr_if.sink   csr
);
   import hlvf_pkg::*;

   localparam int AXES = 3;

   cfg_type      cfg_ff;
   lane_ctl_type ctl;
   logic         busy_ff, busy_in;
   logic         outv_ff, outv_in;
   logic         fbv_ff, clutch_ff, prevt_ff, prevs_ff, nf_ff;
   logic [1:0]   scale_ff;
   logic         nf_in;
   logic [1:0]   scale_in;
   logic         start_ff;
   logic [AXES-1:0] ldone;
   logic signed [31:0] rv [AXES];
   logic signed [31:0] ff [AXES];
   logic signed [31:0] cv [AXES];
   logic signed [31:0] ps [AXES];
   logic signed [31:0] df [AXES];
   logic signed [31:0] ovel [AXES];
   logic signed [31:0] opos [AXES];
   logic signed [31:0] ofrc [AXES];
   logic               accept;

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_enable  <= 1'b1;
         cfg_ff.meas_noise_var <= 32'd131072000;
         cfg_ff.proc_noise_var <= 25'd65536;
         cfg_ff.vel_limit      <= 31'd2013266;
         cfg_ff.force_limit    <= 31'd33554432;
         cfg_ff.force_divisor  <= 8'd5;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_FILTER_ENABLE:  cfg_ff.filter_enable  <= csr.data[0];
            REG_MEAS_NOISE_VAR: cfg_ff.meas_noise_var <= csr.data;
            REG_PROC_NOISE_VAR: cfg_ff.proc_noise_var <= csr.data[24:0];
            REG_VEL_LIMIT:      cfg_ff.vel_limit      <= csr.data[30:0];
            REG_FORCE_LIMIT:    cfg_ff.force_limit    <= csr.data[30:0];
            REG_FORCE_DIVISOR:  cfg_ff.force_divisor  <= csr.data[7:0];
            default: ;
         endcase
      end
   end

   // A new request is taken once the previous response has left.
   assign req.ready = !busy_ff && !outv_ff;
   assign accept    = req.valid && req.ready;

   // Button edges are resolved at acceptance; lanes see the updated mode and scale.
   always_comb begin
      nf_in    = nf_ff;
      scale_in = scale_ff;
      if (req.toggle_button && !prevt_ff) nf_in = !nf_ff;
      if (req.scale_button && !prevs_ff)
         scale_in = (scale_ff >= 2'd2) ? 2'd0 : scale_ff + 2'd1;
   end

   always_comb begin
      busy_in = busy_ff;
      outv_in = outv_ff;
      if (accept) busy_in = 1'b1;
      if (ldone[0]) begin
         busy_in = 1'b0;
         outv_in = 1'b1;
      end
      if (rsp.valid && rsp.ready) outv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         outv_ff  <= 1'b0;
         start_ff <= 1'b0;
         prevt_ff <= 1'b0;
         prevs_ff <= 1'b0;
         nf_ff    <= 1'b0;
         scale_ff <= 2'd1;
      end else begin
         busy_ff  <= busy_in;
         outv_ff  <= outv_in;
         start_ff <= accept;
         if (accept) begin
            prevt_ff <= req.toggle_button;
            prevs_ff <= req.scale_button;
            nf_ff    <= nf_in;
            scale_ff <= scale_in;
         end
      end
      if (accept) begin
         fbv_ff    <= req.fb_valid;
         clutch_ff <= req.clutch_button;
         rv[0] <= req.raw_vel_x;
         rv[1] <= req.raw_vel_y;
         rv[2] <= req.raw_vel_z;
         ff[0] <= req.fb_force_x;
         ff[1] <= req.fb_force_y;
         ff[2] <= req.fb_force_z;
      end
      // The lanes finish together; their results are captured into the response register.
      if (ldone[0]) begin
         for (int a = 0; a < AXES; a++) begin
            ovel[a] <= cv[a];
            opos[a] <= ps[a];
            ofrc[a] <= df[a];
         end
      end
   end

   assign ctl.start    = start_ff;
   assign ctl.fb_valid = fbv_ff;
   assign ctl.clutch   = clutch_ff;
   assign ctl.no_force = nf_ff;
   assign ctl.scale    = scale_ff;

   localparam logic signed [31:0] POS_RST [AXES] = '{32'sd4194304, 32'sd4194304, 32'sd6710886};

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      hlvf_lane #(.POS_RESET(POS_RST[a])) u_lane (
         .clock(clock), .reset(reset), .cfg(cfg_ff), .ctl(ctl),
         .raw_vel(rv[a]), .fb_force(ff[a]), .done(ldone[a]),
         .cmd_vel(cv[a]), .pos(ps[a]), .disp_force(df[a]));
   end

   assign rsp.valid        = outv_ff;
   assign rsp.cmd_vel_x    = ovel[0];
   assign rsp.cmd_vel_y    = ovel[1];
   assign rsp.cmd_vel_z    = ovel[2];
   assign rsp.pos_x        = opos[0];
   assign rsp.pos_y        = opos[1];
   assign rsp.pos_z        = opos[2];
   assign rsp.disp_force_x = ofrc[0];
   assign rsp.disp_force_y = ofrc[1];
   assign rsp.disp_force_z = ofrc[2];
   assign rsp.haptics_off  = nf_ff;
   assign rsp.scale_level  = scale_ff + 2'd1;

`ifndef ASSERT_OFF
   a_lanes_sync: assert property (@(posedge clock) disable iff (reset)
      ldone[0] |-> (ldone == {AXES{1'b1}}))
      else $error("lanes finished apart");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || outv_ff) |-> !req.ready)
      else $error("request taken while busy");
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      scale_ff != 2'd3)
      else $error("scale index out of range");
`endif
endmodule
`default_nettype wire
